// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_SYNC(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/msbr_pkg.sv
// ----------------------------------------------------------------------------
// msbr_pkg
// widths, codes and defaults of the msb-first bit reader
// ----------------------------------------------------------------------------
package msbr_pkg;

    localparam int unsigned DEFAULT_STORE_WORDS = 1024;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned WIN_W   = 64;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned VALUE_W = 64;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 2'd0,
        MODE_REWIND = 2'd1,
        MODE_READ   = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_ADV1 = 4'b0100,
        S_ADV2 = 4'b1000
    } t_state;

endpackage

// File: rtl/msbr_if.sv
// ----------------------------------------------------------------------------
// msbr channel interfaces
// valid/ready channels carrying command words in and read words out
// ----------------------------------------------------------------------------
interface msbr_in_if;
    import msbr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic [BYTE_W-1:0]    byte_in;
    logic [COUNT_W-1:0]   bit_count;

    modport source (output valid, output mode, output byte_in, output bit_count,
                    input ready);
    modport sink   (input valid, input mode, input byte_in, input bit_count,
                    output ready);
endinterface

interface msbr_out_if;
    import msbr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [VALUE_W-1:0]   value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// File: rtl/msb_first_bit_reader.sv
// ----------------------------------------------------------------------------
// msb_first_bit_reader
// packs bytes big-endian into a word memory and reads them back msb first
// ----------------------------------------------------------------------------
// Bytes are appended one per cycle while idle into a single-port-write,
// registered-read memory of STORE_WORDS 32-bit words; a rewind loads word 0
// into a 64-bit window and a read returns 0 to 64 bits right-aligned. An
// append or an unused mode code completes in S_IDLE, a rewind goes through
// S_LOAD, a read of up to 32 bits through S_ADV1 and a longer one through
// S_ADV1 and S_ADV2; reads may wait for the output register to drain. Each
// window refill needs one registered memory read. The memory has no reset
// and needs no clearing pass: words are only read below the fill level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module msb_first_bit_reader #(
    parameter int unsigned STORE_WORDS = msbr_pkg::DEFAULT_STORE_WORDS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    msbr_in_if.sink      i_in,
    msbr_out_if.source   o_out
);
    import msbr_pkg::*;

    localparam int unsigned AW        = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int unsigned NW        = $clog2(STORE_WORDS + 1);
    localparam int unsigned CAP_BYTES = STORE_WORDS * 4;
    localparam int unsigned BW        = $clog2(CAP_BYTES + 1);

    logic [WORD_W-1:0]  mem_store [STORE_WORDS];

    t_state             r_state, n_state;
    logic [BW-1:0]      r_byte_count, n_byte_count;
    logic [WIN_W-1:0]   r_window, n_window;
    logic [6:0]         r_valid_bits, n_valid_bits;
    logic [NW-1:0]      r_next_word, n_next_word;
    logic               r_reading, n_reading;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_go, n_go;
    logic [WORD_W-1:0]  r_acc, n_acc;
    logic               r_out_valid, n_out_valid;
    logic [VALUE_W-1:0] r_out_value, n_out_value;
    logic [WORD_W-1:0]  r_rdata;

    logic               in_acc;
    logic               out_free;
    logic [BW:0]        bc_plus;
    logic [BW-2:0]      stored_words;

    logic [3:0]         mem_we;
    logic [AW-1:0]      wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;

    logic [5:0]         adv_n;
    logic [WORD_W-1:0]  top_bits;
    logic [6:0]         adv_v1;
    logic [WIN_W-1:0]   adv_w1;
    logic               adv_refill;
    logic [WIN_W-1:0]   adv_window;
    logic [6:0]         adv_valid;
    logic [NW-1:0]      adv_next;
    logic               long_read;

    assign i_in.ready  = (r_state == S_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.value = r_out_value;

    assign bc_plus      = {1'b0, r_byte_count} + (BW+1)'(3);
    assign stored_words = bc_plus[BW:2];
    assign long_read    = r_go && (r_count > 7'd32);

    // byte write, whole word cleared on the first byte of a word
    assign wr_addr = r_byte_count[AW+1:2];
    always_comb begin
        mem_we  = 4'b0000;
        wr_data = {4{i_in.byte_in}};
        if (in_acc && (t_mode'(i_in.mode) == MODE_APPEND)
                && (r_byte_count < BW'(CAP_BYTES))) begin
            if (r_byte_count[1:0] == 2'd0) begin
                mem_we  = 4'b1111;
                wr_data = {i_in.byte_in, 24'h000000};
            end else begin
                mem_we = 4'b0001 << (2'd3 - r_byte_count[1:0]);
            end
        end
    end

    // window advance, one memory word per step
    always_comb begin
        adv_n      = (r_state == S_ADV2) ? 6'(r_count - 7'd32)
                   : ((r_count > 7'd32) ? 6'd32 : r_count[5:0]);
        top_bits   = r_window[WIN_W-1:WORD_W] >> (6'd32 - adv_n);
        adv_v1     = r_valid_bits - {1'b0, adv_n};
        adv_w1     = r_window << adv_n;
        adv_refill = (adv_v1 < 7'd32) && ((BW-1)'(r_next_word) < stored_words);
        adv_window = adv_w1;
        adv_valid  = adv_v1;
        adv_next   = r_next_word;
        if (adv_v1 < 7'd32) begin
            if (adv_refill) begin
                adv_window = adv_w1 | ({32'h0, r_rdata} << (7'd32 - adv_v1));
                adv_valid  = adv_v1 + 7'd32;
                adv_next   = r_next_word + NW'(1);
            end else begin
                adv_valid = 7'd64;
            end
        end
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_next_word[AW-1:0];
        if (in_acc && (t_mode'(i_in.mode) == MODE_REWIND)) begin
            rd_en   = 1'b1;
            rd_addr = '0;
        end else if (in_acc && (t_mode'(i_in.mode) == MODE_READ)) begin
            rd_en = 1'b1;
        end else if ((r_state == S_ADV1) && long_read) begin
            rd_en   = 1'b1;
            rd_addr = adv_next[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            if (mem_we[i]) begin
                mem_store[wr_addr][8*i +: 8] <= wr_data[8*i +: 8];
            end
        end
        if (rd_en) begin
            r_rdata <= mem_store[rd_addr];
        end
    end

    always_comb begin
        n_state      = r_state;
        n_byte_count = r_byte_count;
        n_window     = r_window;
        n_valid_bits = r_valid_bits;
        n_next_word  = r_next_word;
        n_reading    = r_reading;
        n_count      = r_count;
        n_go         = r_go;
        n_acc        = r_acc;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_value  = r_out_value;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (t_mode'(i_in.mode))
                        MODE_APPEND: begin
                            if (r_byte_count < BW'(CAP_BYTES)) begin
                                n_byte_count = r_byte_count + BW'(1);
                            end
                        end
                        MODE_REWIND: begin
                            n_state = S_LOAD;
                        end
                        MODE_READ: begin
                            n_state = S_ADV1;
                            n_count = (i_in.bit_count > 7'd64) ? 7'd64 : i_in.bit_count;
                            n_go    = r_reading && (i_in.bit_count != 7'd0);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LOAD: begin
                n_window     = (stored_words != '0) ? {r_rdata, 32'h0} : '0;
                n_valid_bits = 7'd32;
                n_next_word  = NW'(1);
                n_reading    = 1'b1;
                n_state      = S_IDLE;
            end
            S_ADV1: begin
                if (long_read) begin
                    n_window     = adv_window;
                    n_valid_bits = adv_valid;
                    n_next_word  = adv_next;
                    n_acc        = top_bits;
                    n_state      = S_ADV2;
                end else if (out_free) begin
                    if (r_go) begin
                        n_window     = adv_window;
                        n_valid_bits = adv_valid;
                        n_next_word  = adv_next;
                    end
                    n_out_valid = 1'b1;
                    n_out_value = r_go ? {32'h0, top_bits} : '0;
                    n_state     = S_IDLE;
                end
            end
            S_ADV2: begin
                if (out_free) begin
                    n_window     = adv_window;
                    n_valid_bits = adv_valid;
                    n_next_word  = adv_next;
                    n_out_valid  = 1'b1;
                    n_out_value  = ({32'h0, r_acc} << adv_n) | {32'h0, top_bits};
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_byte_count <= '0;
            r_window     <= '0;
            r_valid_bits <= 7'd32;
            r_next_word  <= NW'(1);
            r_reading    <= 1'b0;
            r_go         <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_byte_count <= n_byte_count;
            r_window     <= n_window;
            r_valid_bits <= n_valid_bits;
            r_next_word  <= n_next_word;
            r_reading    <= n_reading;
            r_go         <= n_go;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_count     <= n_count;
        r_acc       <= n_acc;
        r_out_value <= n_out_value;
    end

    `ASSERT_SYNC(a_valid_range, (r_valid_bits >= 7'd32) && (r_valid_bits <= 7'd64), "window valid count out of range")
    `ASSERT_SYNC(a_next_bound, r_next_word <= NW'(STORE_WORDS), "next word index beyond store")
    `ASSERT_SYNC(a_byte_bound, r_byte_count <= BW'(CAP_BYTES), "byte count beyond capacity")
    `ASSERT_SYNC(a_adv2_long, (r_state != S_ADV2) || long_read, "second step without a long read")
    `ASSERT_NEXT(a_read_done, (r_state == S_ADV1) && !long_read && out_free, r_out_valid && (r_state == S_IDLE), "short read word not delivered")

endmodule
